[hw/rtl/md5c_pkg.sv]
package md5c_pkg;

    // Request kinds carried in the input tuser.
    localparam logic [1:0] REQ_KEY   = 2'd0;
    localparam logic [1:0] REQ_SALT  = 2'd1;
    localparam logic [1:0] REQ_START = 2'd2;

    // Characters used by the salt parser, the result string and the padding.
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_PAD    = 8'h80;

    // Index of the last chained round after the initial digest.
    localparam logic [9:0] LAST_ROUND = 10'd999;

    // MD5 chaining values at the start of a message.
    localparam logic [31:0] MD5_IV_A = 32'h67452301;
    localparam logic [31:0] MD5_IV_B = 32'hefcdab89;
    localparam logic [31:0] MD5_IV_C = 32'h98badcfe;
    localparam logic [31:0] MD5_IV_D = 32'h10325476;

    // Top level sequencer states.
    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_FILL = 6'b000010,
        ST_PAD  = 6'b000100,
        ST_HASH = 6'b001000,
        ST_OUT  = 6'b010000,
        ST_ERR  = 6'b100000
    } md5c_state_t;

    // Which message is being built.
    typedef enum logic [1:0] {
        PH_ALT   = 2'd0,
        PH_INIT  = 2'd1,
        PH_ROUND = 2'd2
    } md5c_phase_t;

    // Pieces a message is assembled from.
    typedef enum logic [2:0] {
        SEG_KEY   = 3'd0,
        SEG_SALT  = 3'd1,
        SEG_MAGIC = 3'd2,
        SEG_DIGN  = 3'd3,
        SEG_DIG16 = 3'd4,
        SEG_BITS  = 3'd5,
        SEG_NONE  = 3'd6,
        SEG_END   = 3'd7
    } md5c_seg_t;

    // Control from the sequencer to the compression unit.
    typedef struct packed {
        logic       we;
        logic [5:0] addr;
        logic [7:0] data;
        logic       start;
    } md5c_ctl_t;

    // Additive constant of each MD5 step.
    function automatic logic [31:0] md5c_k(input logic [5:0] j);
        logic [31:0] k;
        case (j)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    // Rotate amount of each MD5 step.
    function automatic logic [4:0] md5c_s(input logic [5:0] j);
        logic [4:0] s;
        case ({j[5:4], j[1:0]})
            4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
            4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
            default: s = 5'd7;
        endcase
        return s;
    endfunction

endpackage

[hw/rtl/md5c_core.sv]
module md5c_core
    import md5c_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  md5c_ctl_t    ctl,
    output logic         done,
    output logic [127:0] digest
);

    logic [31:0] blk_mem [16];
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [5:0]  j_reg;
    logic        run_reg, fin_reg, done_reg;
    logic [127:0] digest_reg;

    logic [31:0] f, m, t, rot;
    logic [3:0]  jl, g;
    logic [63:0] rot_wide;

    // The block buffer takes one message byte a cycle, little-endian in its word.
    always_ff @(posedge aclk) begin
        if (ctl.we) begin
            blk_mem[ctl.addr[5:2]][8*ctl.addr[1:0] +: 8] <= ctl.data;
        end
    end

    // One MD5 step: round function, message word, constant and rotate.
    always_comb begin
        jl = j_reg[3:0];
        case (j_reg[5:4])
            2'd0: begin
                f = (b_reg & c_reg) | (~b_reg & d_reg);
                g = jl;
            end
            2'd1: begin
                f = (b_reg & d_reg) | (c_reg & ~d_reg);
                g = jl * 4'd5 + 4'd1;
            end
            2'd2: begin
                f = b_reg ^ c_reg ^ d_reg;
                g = jl * 4'd3 + 4'd5;
            end
            default: begin
                f = c_reg ^ (b_reg | ~d_reg);
                g = jl * 4'd7;
            end
        endcase
        m        = blk_mem[g];
        t        = f + a_reg + md5c_k(j_reg) + m;
        rot_wide = {t, t} << md5c_s(j_reg);
        rot      = rot_wide[63:32];
    end

    // Step sequencer: 64 steps, then the chaining add into the digest.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            j_reg    <= 6'd0;
        end else begin
            done_reg <= fin_reg;
            fin_reg  <= 1'b0;
            if (ctl.start) begin
                a_reg   <= MD5_IV_A;
                b_reg   <= MD5_IV_B;
                c_reg   <= MD5_IV_C;
                d_reg   <= MD5_IV_D;
                j_reg   <= 6'd0;
                run_reg <= 1'b1;
            end else if (run_reg) begin
                a_reg <= d_reg;
                d_reg <= c_reg;
                c_reg <= b_reg;
                b_reg <= b_reg + rot;
                j_reg <= j_reg + 6'd1;
                if (j_reg == 6'd63) begin
                    run_reg <= 1'b0;
                    fin_reg <= 1'b1;
                end
            end
            if (fin_reg) begin
                digest_reg <= {d_reg + MD5_IV_D, c_reg + MD5_IV_C,
                               b_reg + MD5_IV_B, a_reg + MD5_IV_A};
            end
        end
    end

    assign done   = done_reg;
    assign digest = digest_reg;

endmodule

[hw/rtl/md5_crypt_password_hash.sv]
// Key and salt words are taken one per cycle while the block is idle.
// A start word runs 1002 MD5 messages; each is assembled and padded in the
// block buffer and then hashed in the shared MD5 step unit before the next
// one starts, and the first result word follows the last of them.
// Results then leave one word per cycle while the output is taken.
// Reset (aresetn, synchronous, active low) empties the key and salt counters.
module md5_crypt_password_hash
    import md5c_pkg::*;
#(
    parameter int MAX_KEY  = 15,
    parameter int MAX_SALT = 8
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // data_byte
    input  logic [1:0] s_tuser,   // req_type
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_char
    output logic       m_tlast,
    output logic [0:0] m_tuser    // error
);

    localparam int KW  = $clog2(MAX_KEY + 1);
    localparam int SW  = $clog2(MAX_SALT + 1);
    localparam int KIW = (MAX_KEY > 1) ? $clog2(MAX_KEY) : 1;
    localparam int SIW = (MAX_SALT > 1) ? $clog2(MAX_SALT) : 1;

    logic [7:0] key_store  [MAX_KEY];
    logic [7:0] salt_store [MAX_SALT];

    md5c_state_t state_reg, state_next;
    md5c_phase_t phase_reg, phase_next;
    logic [2:0]    sidx_reg, sidx_next;
    logic [4:0]    pos_reg, pos_next;
    logic [5:0]    len_reg, len_next;
    logic [5:0]    padp_reg, padp_next;
    logic [KW-1:0] bits_reg, bits_next;
    logic [9:0]    iter_reg, iter_next;
    logic [1:0]    m3_reg, m3_next;
    logic [2:0]    m7_reg, m7_next;
    logic [KW-1:0] key_count_reg, key_count_next;
    logic [SW-1:0] salt_count_reg, salt_count_next;
    logic [1:0]    raw_pos_reg, raw_pos_next;
    logic          salt_closed_reg, salt_closed_next;
    logic          key_ovf_reg, key_ovf_next;
    logic [5:0]    oidx_reg, oidx_next;
    logic          m_valid_reg, m_valid_next;
    logic [7:0]    m_char_reg, m_char_next;
    logic          m_last_reg, m_last_next;
    logic          m_err_reg, m_err_next;

    md5c_ctl_t    ctl;
    logic         core_done;
    logic [127:0] digest;

    logic       s_accept, out_free, key_we, salt_we;
    md5c_seg_t  seg;
    logic [4:0] seg_len;
    logic [7:0] seg_byte, pad_byte;
    logic [8:0] bit_len;
    logic [5:0] sc6, bidx6, so6;
    logic [4:0] bidx;
    logic [3:0] gi0, gi1, gi2;
    logic [23:0] grp_w;
    logic [5:0] six;
    logic [7:0] out_char;
    logic       out_last;

    md5c_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .done    (core_done),
        .digest  (digest)
    );

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd2) begin
            c = 8'h2e + {2'b00, v};
        end else if (v < 6'd12) begin
            c = 8'h30 + {2'b00, v} - 8'd2;
        end else if (v < 6'd38) begin
            c = 8'h41 + {2'b00, v} - 8'd12;
        end else begin
            c = 8'h61 + {2'b00, v} - 8'd38;
        end
        return c;
    endfunction

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // Piece of the message at the current piece index.
    always_comb begin
        seg = SEG_END;
        case (phase_reg)
            PH_ALT: begin
                case (sidx_reg)
                    3'd0: seg = SEG_KEY;
                    3'd1: seg = SEG_SALT;
                    3'd2: seg = SEG_KEY;
                    default: seg = SEG_END;
                endcase
            end
            PH_INIT: begin
                case (sidx_reg)
                    3'd0: seg = SEG_KEY;
                    3'd1: seg = SEG_MAGIC;
                    3'd2: seg = SEG_SALT;
                    3'd3: seg = SEG_DIGN;
                    3'd4: seg = SEG_BITS;
                    default: seg = SEG_END;
                endcase
            end
            default: begin
                case (sidx_reg)
                    3'd0: seg = iter_reg[0] ? SEG_KEY : SEG_DIG16;
                    3'd1: seg = (m3_reg != 2'd0) ? SEG_SALT : SEG_NONE;
                    3'd2: seg = (m7_reg != 3'd0) ? SEG_KEY : SEG_NONE;
                    3'd3: seg = iter_reg[0] ? SEG_DIG16 : SEG_KEY;
                    default: seg = SEG_END;
                endcase
            end
        endcase
    end

    // Length and current byte of that piece.
    always_comb begin
        case (seg)
            SEG_KEY: begin
                seg_len  = 5'(key_count_reg);
                seg_byte = key_store[pos_reg[KIW-1:0]];
            end
            SEG_SALT: begin
                seg_len  = 5'(salt_count_reg);
                seg_byte = salt_store[pos_reg[SIW-1:0]];
            end
            SEG_MAGIC: begin
                seg_len  = 5'd3;
                seg_byte = (pos_reg == 5'd1) ? CH_ONE : CH_DOLLAR;
            end
            SEG_DIGN: begin
                seg_len  = 5'(key_count_reg);
                seg_byte = digest[8*pos_reg[3:0] +: 8];
            end
            SEG_DIG16: begin
                seg_len  = 5'd16;
                seg_byte = digest[8*pos_reg[3:0] +: 8];
            end
            SEG_BITS: begin
                seg_len  = 5'd0;
                seg_byte = bits_reg[0] ? 8'h00 : key_store[0];
            end
            default: begin
                seg_len  = 5'd0;
                seg_byte = 8'h00;
            end
        endcase
    end

    // Padding: end marker, zeros, then the bit length in little-endian order.
    always_comb begin
        bit_len = {len_reg, 3'b000};
        if (padp_reg == len_reg) begin
            pad_byte = CH_PAD;
        end else if (padp_reg == 6'd56) begin
            pad_byte = bit_len[7:0];
        end else if (padp_reg == 6'd57) begin
            pad_byte = {7'd0, bit_len[8]};
        end else begin
            pad_byte = 8'h00;
        end
    end

    // Result character at the output index.
    always_comb begin
        sc6   = 6'(salt_count_reg);
        so6   = oidx_reg - 6'd3;
        bidx6 = oidx_reg - 6'd4 - sc6;
        bidx  = bidx6[4:0];
        case (bidx[4:2])
            3'd0: begin gi0 = 4'd0; gi1 = 4'd6;  gi2 = 4'd12; end
            3'd1: begin gi0 = 4'd1; gi1 = 4'd7;  gi2 = 4'd13; end
            3'd2: begin gi0 = 4'd2; gi1 = 4'd8;  gi2 = 4'd14; end
            3'd3: begin gi0 = 4'd3; gi1 = 4'd9;  gi2 = 4'd15; end
            3'd4: begin gi0 = 4'd4; gi1 = 4'd10; gi2 = 4'd5;  end
            default: begin gi0 = 4'd0; gi1 = 4'd0; gi2 = 4'd11; end
        endcase
        if (bidx[4:2] == 3'd5) begin
            grp_w = {16'd0, digest[8*gi2 +: 8]};
        end else begin
            grp_w = {digest[8*gi0 +: 8], digest[8*gi1 +: 8], digest[8*gi2 +: 8]};
        end
        case (bidx[1:0])
            2'd0: six = grp_w[5:0];
            2'd1: six = grp_w[11:6];
            2'd2: six = grp_w[17:12];
            default: six = grp_w[23:18];
        endcase
        out_last = 1'b0;
        if (oidx_reg < 6'd3) begin
            out_char = (oidx_reg == 6'd1) ? CH_ONE : CH_DOLLAR;
        end else if (oidx_reg < 6'd3 + sc6) begin
            out_char = salt_store[so6[SIW-1:0]];
        end else if (oidx_reg == 6'd3 + sc6) begin
            out_char = CH_DOLLAR;
        end else begin
            out_char = b64_char(six);
            out_last = (bidx == 5'd21);
        end
    end

    // Sequencer next state.
    always_comb begin
        state_next       = state_reg;
        phase_next       = phase_reg;
        sidx_next        = sidx_reg;
        pos_next         = pos_reg;
        len_next         = len_reg;
        padp_next        = padp_reg;
        bits_next        = bits_reg;
        iter_next        = iter_reg;
        m3_next          = m3_reg;
        m7_next          = m7_reg;
        key_count_next   = key_count_reg;
        salt_count_next  = salt_count_reg;
        raw_pos_next     = raw_pos_reg;
        salt_closed_next = salt_closed_reg;
        key_ovf_next     = key_ovf_reg;
        oidx_next        = oidx_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        m_char_next      = m_char_reg;
        m_last_next      = m_last_reg;
        m_err_next       = m_err_reg;
        key_we           = 1'b0;
        salt_we          = 1'b0;
        ctl              = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    case (s_tuser)
                        REQ_KEY: begin
                            if (key_count_reg < KW'(MAX_KEY)) begin
                                key_we         = 1'b1;
                                key_count_next = key_count_reg + 1'b1;
                            end else begin
                                key_ovf_next = 1'b1;
                            end
                        end
                        REQ_SALT: begin
                            if (!salt_closed_reg) begin
                                case (raw_pos_reg)
                                    2'd0: begin
                                        if (s_tdata == CH_DOLLAR) begin
                                            raw_pos_next = 2'd1;
                                        end else if (s_tdata == 8'h00) begin
                                            raw_pos_next     = 2'd3;
                                            salt_closed_next = 1'b1;
                                        end else begin
                                            raw_pos_next = 2'd3;
                                            salt_we      = 1'b1;
                                        end
                                    end
                                    2'd1: begin
                                        if (s_tdata == CH_ONE) begin
                                            raw_pos_next = 2'd2;
                                        end else begin
                                            salt_closed_next = 1'b1;
                                        end
                                    end
                                    2'd2: begin
                                        if (s_tdata == CH_DOLLAR) begin
                                            raw_pos_next = 2'd3;
                                        end else begin
                                            salt_closed_next = 1'b1;
                                        end
                                    end
                                    default: begin
                                        if (s_tdata == CH_DOLLAR || s_tdata == 8'h00) begin
                                            salt_closed_next = 1'b1;
                                        end else begin
                                            salt_we = 1'b1;
                                        end
                                    end
                                endcase
                                // Adding a salt byte may fill the salt.
                                if (salt_we) begin
                                    if (salt_count_reg < SW'(MAX_SALT)) begin
                                        salt_count_next = salt_count_reg + 1'b1;
                                        if (salt_count_reg + 1'b1 >= SW'(MAX_SALT)) begin
                                            salt_closed_next = 1'b1;
                                        end
                                    end else begin
                                        salt_we          = 1'b0;
                                        salt_closed_next = 1'b1;
                                    end
                                end
                            end
                        end
                        REQ_START: begin
                            if (key_ovf_reg) begin
                                state_next = ST_ERR;
                            end else begin
                                state_next = ST_FILL;
                                phase_next = PH_ALT;
                                sidx_next  = 3'd0;
                                pos_next   = 5'd0;
                                len_next   = 6'd0;
                                bits_next  = key_count_reg;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ST_FILL: begin
                if (seg == SEG_END) begin
                    state_next = ST_PAD;
                    padp_next  = len_reg;
                end else if (seg == SEG_BITS) begin
                    if (bits_reg != '0) begin
                        ctl.we    = 1'b1;
                        ctl.addr  = len_reg;
                        ctl.data  = seg_byte;
                        bits_next = bits_reg >> 1;
                        len_next  = len_reg + 6'd1;
                    end else begin
                        sidx_next = sidx_reg + 3'd1;
                    end
                end else if (pos_reg < seg_len) begin
                    ctl.we   = 1'b1;
                    ctl.addr = len_reg;
                    ctl.data = seg_byte;
                    pos_next = pos_reg + 5'd1;
                    len_next = len_reg + 6'd1;
                end else begin
                    pos_next  = 5'd0;
                    sidx_next = sidx_reg + 3'd1;
                end
            end

            ST_PAD: begin
                ctl.we    = 1'b1;
                ctl.addr  = padp_reg;
                ctl.data  = pad_byte;
                padp_next = padp_reg + 6'd1;
                if (padp_reg == 6'd63) begin
                    ctl.start  = 1'b1;
                    state_next = ST_HASH;
                end
            end

            ST_HASH: begin
                if (core_done) begin
                    state_next = ST_FILL;
                    sidx_next  = 3'd0;
                    pos_next   = 5'd0;
                    len_next   = 6'd0;
                    bits_next  = key_count_reg;
                    case (phase_reg)
                        PH_ALT: begin
                            phase_next = PH_INIT;
                        end
                        PH_INIT: begin
                            phase_next = PH_ROUND;
                            iter_next  = 10'd0;
                            m3_next    = 2'd0;
                            m7_next    = 3'd0;
                        end
                        default: begin
                            if (iter_reg == LAST_ROUND) begin
                                state_next = ST_OUT;
                                oidx_next  = 6'd0;
                            end else begin
                                iter_next = iter_reg + 10'd1;
                                m3_next   = (m3_reg == 2'd2) ? 2'd0 : m3_reg + 2'd1;
                                m7_next   = (m7_reg == 3'd6) ? 3'd0 : m7_reg + 3'd1;
                            end
                        end
                    endcase
                end
            end

            ST_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_char_next  = out_char;
                    m_last_next  = out_last;
                    m_err_next   = 1'b0;
                    oidx_next    = oidx_reg + 6'd1;
                    if (out_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_ERR: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_char_next  = 8'h00;
                    m_last_next  = 1'b1;
                    m_err_next   = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // A finished run returns the stores to empty.
        if ((state_reg == ST_OUT && out_free && out_last) ||
            (state_reg == ST_ERR && out_free)) begin
            key_count_next   = '0;
            salt_count_next  = '0;
            raw_pos_next     = 2'd0;
            salt_closed_next = 1'b0;
            key_ovf_next     = 1'b0;
            iter_next        = 10'd0;
        end
    end

    // Key and salt stores.
    always_ff @(posedge aclk) begin
        if (key_we) begin
            key_store[key_count_reg[KIW-1:0]] <= s_tdata;
        end
        if (salt_we) begin
            salt_store[salt_count_reg[SIW-1:0]] <= s_tdata;
        end
    end

    // Sequencer and output registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            phase_reg       <= PH_ALT;
            sidx_reg        <= 3'd0;
            pos_reg         <= 5'd0;
            len_reg         <= 6'd0;
            padp_reg        <= 6'd0;
            bits_reg        <= '0;
            iter_reg        <= 10'd0;
            m3_reg          <= 2'd0;
            m7_reg          <= 3'd0;
            key_count_reg   <= '0;
            salt_count_reg  <= '0;
            raw_pos_reg     <= 2'd0;
            salt_closed_reg <= 1'b0;
            key_ovf_reg     <= 1'b0;
            oidx_reg        <= 6'd0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            phase_reg       <= phase_next;
            sidx_reg        <= sidx_next;
            pos_reg         <= pos_next;
            len_reg         <= len_next;
            padp_reg        <= padp_next;
            bits_reg        <= bits_next;
            iter_reg        <= iter_next;
            m3_reg          <= m3_next;
            m7_reg          <= m7_next;
            key_count_reg   <= key_count_next;
            salt_count_reg  <= salt_count_next;
            raw_pos_reg     <= raw_pos_next;
            salt_closed_reg <= salt_closed_next;
            key_ovf_reg     <= key_ovf_next;
            oidx_reg        <= oidx_next;
            m_valid_reg     <= m_valid_next;
        end
        m_char_reg <= m_char_next;
        m_last_reg <= m_last_next;
        m_err_reg  <= m_err_next;
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_char_reg;
    assign m_tlast    = m_last_reg;
    assign m_tuser[0] = m_err_reg;

endmodule

[tb/tb_md5_crypt_password_hash.sv]
`timescale 1ns / 1ps

module tb_md5_crypt_password_hash;
    import md5c_pkg::*;

    localparam int KEY_CAP    = 15;
    localparam int SALT_CAP   = 8;
    localparam int WDOG_LIMIT = 400000;
    localparam int HOLD_LEN   = 600;

    // Request kind that the block ignores.
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;

    typedef logic [7:0] dig_t [16];
    typedef logic [7:0] msg_t [$];

    typedef struct {
        logic [1:0] kind;
        logic [7:0] data;
    } req_word_t;

    typedef struct {
        logic [7:0] ch;
        logic       last;
        logic       err;
    } char_word_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'd0;   // data_byte
    logic [1:0] s_tuser = 2'd0;   // req_type
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;          // out_char
    logic       m_tlast;
    logic [0:0] m_tuser;          // error

    md5_crypt_password_hash u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .m_tuser(m_tuser)
    );

    always #4 aclk = ~aclk;

    req_word_t  pending_words[$];
    char_word_t crypt_chars[$];
    int         errors = 0;
    int         words_in = 0;
    int         chars_out = 0;
    int         hashes_done = 0;
    int         overflows_done = 0;
    int         idle_cycles = 0;
    int         hold_left = 0;
    bit         hold_done = 1'b0;

    // Predictor state.
    logic [7:0] key_bytes[$];
    logic [7:0] salt_bytes[$];
    int         prefix_pos;
    bit         salt_done;
    bit         key_long;
    logic [31:0] sine_k[64];
    int unsigned rot_amt[16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

    initial begin
        real r;
        for (int i = 0; i < 64; i++) begin
            r = $sin(i + 1);
            if (r < 0.0) r = -r;
            sine_k[i] = 32'(longint'($floor(r * 4294967296.0)));
        end
    end

    function automatic dig_t md5_of(msg_t m);
        logic [7:0]  blk[$];
        logic [63:0] bits;
        logic [31:0] h[4], a, b, c, d, f, t, w[16];
        int          g;
        dig_t        out;
        bits = 64'(m.size()) * 8;
        blk = m;
        blk.push_back(CH_PAD);
        while (blk.size() % 64 != 56) blk.push_back(8'd0);
        for (int i = 0; i < 8; i++) blk.push_back(bits[8*i +: 8]);
        h = '{MD5_IV_A, MD5_IV_B, MD5_IV_C, MD5_IV_D};
        for (int o = 0; o < blk.size(); o += 64) begin
            for (int j = 0; j < 16; j++)
                w[j] = {blk[o+4*j+3], blk[o+4*j+2], blk[o+4*j+1], blk[o+4*j]};
            a = h[0]; b = h[1]; c = h[2]; d = h[3];
            for (int j = 0; j < 64; j++) begin
                if (j < 16)      begin f = (b & c) | (~b & d); g = j;              end
                else if (j < 32) begin f = (b & d) | (c & ~d); g = (5*j + 1) % 16; end
                else if (j < 48) begin f = b ^ c ^ d;          g = (3*j + 5) % 16; end
                else             begin f = c ^ (b | ~d);       g = (7*j) % 16;     end
                t = f + a + sine_k[j] + w[g];
                a = d; d = c; c = b;
                b = b + ((t << rot_amt[(j/16)*4 + j%4]) | (t >> (32 - rot_amt[(j/16)*4 + j%4])));
            end
            h[0] += a; h[1] += b; h[2] += c; h[3] += d;
        end
        for (int i = 0; i < 16; i++) out[i] = h[i/4][8*(i%4) +: 8];
        return out;
    endfunction

    function automatic void clear_stores();
        key_bytes.delete();
        salt_bytes.delete();
        prefix_pos = 0;
        salt_done = 1'b0;
        key_long = 1'b0;
    endfunction

    function automatic void add_salt(logic [7:0] v);
        if (salt_bytes.size() < SALT_CAP) salt_bytes.push_back(v);
        if (salt_bytes.size() >= SALT_CAP) salt_done = 1'b1;
    endfunction

    function automatic void push_char(logic [7:0] ch, logic last, logic err);
        char_word_t e;
        e.ch = ch; e.last = last; e.err = err;
        crypt_chars.push_back(e);
    endfunction

    // Run the full crypt computation and queue the result string.
    function automatic void predict_crypt();
        string  alpha = "./0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz";
        msg_t   m;
        dig_t   dg;
        int     grp[6][3] = '{'{0,6,12}, '{1,7,13}, '{2,8,14}, '{3,9,15}, '{4,10,5}, '{0,0,11}};
        logic [23:0] v;
        int     n;
        m = {key_bytes, salt_bytes, key_bytes};
        dg = md5_of(m);
        m = {key_bytes, CH_DOLLAR, CH_ONE, CH_DOLLAR, salt_bytes};
        for (int i = 0; i < key_bytes.size(); i++) m.push_back(dg[i]);
        for (int c = key_bytes.size(); c > 0; c >>= 1)
            m.push_back((c & 1) ? 8'd0 : key_bytes[0]);
        dg = md5_of(m);
        for (int i = 0; i < 1000; i++) begin
            m.delete();
            if (i & 1) m = {m, key_bytes}; else for (int k = 0; k < 16; k++) m.push_back(dg[k]);
            if (i % 3) m = {m, salt_bytes};
            if (i % 7) m = {m, key_bytes};
            if (i & 1) for (int k = 0; k < 16; k++) m.push_back(dg[k]); else m = {m, key_bytes};
            dg = md5_of(m);
        end
        push_char(CH_DOLLAR, 0, 0); push_char(CH_ONE, 0, 0); push_char(CH_DOLLAR, 0, 0);
        foreach (salt_bytes[i]) push_char(salt_bytes[i], 0, 0);
        push_char(CH_DOLLAR, 0, 0);
        for (int gi = 0; gi < 6; gi++) begin
            v = (gi < 5) ? {dg[grp[gi][0]], dg[grp[gi][1]], dg[grp[gi][2]]} : {16'd0, dg[11]};
            n = (gi == 5) ? 2 : 4;
            for (int q = 0; q < n; q++) begin
                push_char(8'(alpha[v[5:0]]), (gi == 5 && q == 1), 0);
                v = v >> 6;
            end
        end
    endfunction

    // Update the predictor with one accepted word.
    function automatic void take_word(logic [1:0] kind, logic [7:0] v);
        case (kind)
            REQ_KEY: begin
                if (key_bytes.size() < KEY_CAP) key_bytes.push_back(v);
                else key_long = 1'b1;
            end
            REQ_SALT: begin
                if (!salt_done) begin
                    case (prefix_pos)
                        0: begin
                            if (v == CH_DOLLAR) prefix_pos = 1;
                            else if (v == 8'd0) begin prefix_pos = 3; salt_done = 1'b1; end
                            else begin prefix_pos = 3; add_salt(v); end
                        end
                        1: if (v == CH_ONE) prefix_pos = 2; else salt_done = 1'b1;
                        2: if (v == CH_DOLLAR) prefix_pos = 3; else salt_done = 1'b1;
                        default: if (v == CH_DOLLAR || v == 8'd0) salt_done = 1'b1;
                                 else add_salt(v);
                    endcase
                end
            end
            REQ_START: begin
                if (key_long) begin
                    push_char(8'd0, 1, 1);
                    overflows_done++;
                end else begin
                    predict_crypt();
                    hashes_done++;
                end
                clear_stores();
            end
            default: ;
        endcase
    endfunction

    function automatic void queue_word(logic [1:0] kind, logic [7:0] v);
        req_word_t w;
        w.kind = kind; w.data = v;
        pending_words.push_back(w);
    endfunction

    function automatic void queue_str(logic [1:0] kind, string s);
        for (int i = 0; i < s.len(); i++) queue_word(kind, 8'(s[i]));
    endfunction

    function automatic logic [7:0] salt_char();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return CH_DOLLAR;
        if (r == 1) return 8'd0;
        return 8'($urandom_range(1, 255));
    endfunction

    // Idle rates follow the progress of the run: receiver-heavy, sender-heavy, none.
    function automatic int send_idle_pct();
        if (words_in < 80) return 22;
        if (words_in < 160) return 65;
        return 0;
    endfunction

    function automatic int recv_idle_pct();
        if (words_in < 80) return 65;
        if (words_in < 160) return 22;
        return 0;
    endfunction

    // Stimulus and end of run.
    initial begin
        int n_hash, n_seq;
        clear_stores();
        // Directed: common case with full prefix and a salt closed by length.
        queue_str(REQ_KEY, "password");
        queue_str(REQ_SALT, "$1$saltsaltX");
        queue_word(REQ_START, 8'h00);
        // Longest key with zero and all-ones bytes, salt closed by '$', unknown request.
        queue_word(REQ_KEY, 8'h00); queue_word(REQ_KEY, 8'hFF);
        queue_str(REQ_KEY, "abcdefghijklm");
        queue_word(REQ_UNKNOWN, 8'hFF);
        queue_str(REQ_SALT, "ab$cd");
        queue_word(REQ_START, 8'hFF);
        // Key too long gives a single error word.
        queue_str(REQ_KEY, "0123456789abcdefg");
        queue_str(REQ_SALT, "xy");
        queue_word(REQ_START, 8'h00);
        // Unfinished prefix leaves the salt empty.
        queue_word(REQ_KEY, 8'h80);
        queue_str(REQ_SALT, "$1");
        queue_word(REQ_START, 8'h00);

        // Random sequences: mostly overflow runs, a few full hashes for depth.
        n_hash = 0;
        n_seq = 0;
        while (pending_words.size() < 220) begin
            bit do_hash;
            int klen, slen, form;
            do_hash = (n_seq % 4 == 1) && (n_hash < 3);
            klen = do_hash ? $urandom_range(0, KEY_CAP) : $urandom_range(KEY_CAP + 1, KEY_CAP + 5);
            for (int i = 0; i < klen; i++) queue_word(REQ_KEY, 8'($urandom_range(0, 255)));
            form = $urandom_range(0, 3);
            if (form == 0) queue_str(REQ_SALT, "$1$");
            else if (form == 1) begin
                queue_word(REQ_SALT, CH_DOLLAR);
                queue_word(REQ_SALT, 8'($urandom_range(0, 255)));
            end
            slen = $urandom_range(0, 10);
            for (int i = 0; i < slen; i++) queue_word(REQ_SALT, salt_char());
            if ($urandom_range(0, 3) == 0) queue_word(REQ_UNKNOWN, 8'($urandom_range(0, 255)));
            queue_word(REQ_START, 8'($urandom_range(0, 255)));
            if (do_hash) n_hash++;
            n_seq++;
        end

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        while (pending_words.size() != 0 || s_tvalid || crypt_chars.size() != 0)
            @(posedge aclk);
        repeat (200) @(posedge aclk);
        $display("Ran %0d request words: %0d full crypt hashes and %0d long-key errors,",
                 words_in, hashes_done, overflows_done);
        $display("checked %0d result characters under varied idling and one long output stall.",
                 chars_out);
        if (errors == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end

    // Driver: offer queued words, predicting each on acceptance.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                take_word(s_tuser, s_tdata);
                words_in++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
                    s_tvalid <= 1'b1;
                    s_tuser <= pending_words[0].kind;
                    s_tdata <= pending_words[0].data;
                    void'(pending_words.pop_front());
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls plus one long hold-off on the first result word.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else if (!hold_done && m_tvalid) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_LEN;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct());
        end
    end

    // Monitor: compare each result word with the oldest expected one.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            chars_out++;
            if (crypt_chars.size() == 0) begin
                $display("%0t: unexpected word char=%h last=%b err=%b",
                         $time, m_tdata, m_tlast, m_tuser);
                errors++;
            end else begin
                if (m_tdata !== crypt_chars[0].ch || m_tlast !== crypt_chars[0].last ||
                    m_tuser[0] !== crypt_chars[0].err) begin
                    $display("%0t: mismatch expected char=%h last=%b err=%b %s=%h last=%b err=%b",
                             $time, crypt_chars[0].ch, crypt_chars[0].last, crypt_chars[0].err,
                             "actual char", m_tdata, m_tlast, m_tuser);
                    errors++;
                end
                void'(crypt_chars.pop_front());
            end
        end
    end

    // Watchdog on cycles without any word moving.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WDOG_LIMIT) begin
            $display("Timeout after %0d cycles with no word accepted.", idle_cycles);
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
